// ===== rtl/sifr_pkg.sv =====
`timescale 1ns / 1ps

package sifr_pkg;

  localparam logic [7:0] FlagByte  = 8'h7e;
  localparam logic [7:0] EscByte   = 8'h7d;
  localparam logic [7:0] EscFlag   = 8'h5e;
  localparam logic [7:0] EscEsc    = 8'h5d;
  localparam logic [7:0] CtrlSeq0  = 8'h00;
  localparam logic [7:0] CtrlSeq1  = 8'h40;
  localparam logic [7:0] ReplyRr0  = 8'h05;
  localparam logic [7:0] ReplyRr1  = 8'h85;
  localparam logic [7:0] ReplyRej0 = 8'h01;
  localparam logic [7:0] ReplyRej1 = 8'h81;

  localparam logic [7:0] CmdAddrReset = 8'd3;
  localparam logic [7:0] DiscReset    = 8'd11;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DISC   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_CMD_ADDR = 1'b0,
    CFG_DISC     = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CTRL = 6'b001000,
    PH_DATA = 6'b010000,
    PH_ESC  = 6'b100000
  } phase_e;

endpackage

// ===== rtl/stuffed_info_frame_receiver.sv =====
`timescale 1ns / 1ps

// Receives a raw serial byte stream one byte per cycle, finds information frames
// (flag, address, control, header check), destuffs the payload and hands out each
// payload byte one byte late so the trailing xor check byte is never shown. A closing
// flag gives an accept (RR reply, sequence bit toggles) or a reject (REJ reply); a
// disconnect control gives a disconnect result. The frame state machine and the xor
// run between the input and a single result register, and results appear the cycle
// after the byte that causes them. A byte is taken every cycle while the result
// register is empty or being drained; in_stall_o rises only while a waiting result
// is held off by out_stall_i. Configuration writes apply from the next cycle.
module stuffed_info_frame_receiver
  import sifr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024,
  parameter int unsigned LenW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [LenW-1:0] payload_length_o,
  output logic [7:0]      reply_control_o
);

  logic [7:0] cmd_addr_q, disc_code_q;
  phase_e     phase_q, phase_d;
  logic       seq_q, seq_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic [LenW-1:0] count_q, count_d;
  logic       ovf_q, ovf_d;

  logic       out_valid_q, out_valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0] reply_q, reply_d;

  logic       accept;
  logic       emit;
  logic       take;
  logic [7:0] take_byte;
  logic       seq_ok;
  logic       frame_ok;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign seq_ok = ((rx_byte_i == CtrlSeq0) && !seq_q) || ((rx_byte_i == CtrlSeq1) && seq_q);
  assign frame_ok = held_valid_q && (count_q != '0) && !ovf_q && (xor_q == held_q);

  always_comb begin
    phase_d      = phase_q;
    seq_d        = seq_q;
    hdr_d        = hdr_q;
    xor_d        = xor_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    emit         = 1'b0;
    take         = 1'b0;
    take_byte    = rx_byte_i;
    kind_d       = KIND_DATA;
    pbyte_d      = '0;
    len_d        = '0;
    reply_d      = '0;

    unique case (phase_q)
      PH_FLAG: begin
        if (rx_byte_i == cmd_addr_q) begin
          phase_d = PH_ADDR;
        end else if (rx_byte_i != FlagByte) begin
          phase_d = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (seq_ok) begin
          hdr_d   = rx_byte_i ^ cmd_addr_q;
          phase_d = PH_CTRL;
        end else if (rx_byte_i == disc_code_q) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          kind_d  = KIND_DISC;
          reply_d = disc_code_q;
        end else begin
          phase_d = (rx_byte_i == FlagByte) ? PH_FLAG : PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte_i == hdr_q) begin
          phase_d      = PH_DATA;
          xor_d        = '0;
          held_d       = '0;
          held_valid_d = 1'b0;
          count_d      = '0;
          ovf_d        = 1'b0;
        end else begin
          phase_d = (rx_byte_i == FlagByte) ? PH_FLAG : PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_byte_i == EscByte) begin
          phase_d = PH_ESC;
        end else if (rx_byte_i == FlagByte) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          if (frame_ok) begin
            seq_d   = ~seq_q;
            kind_d  = KIND_ACCEPT;
            len_d   = count_q;
            reply_d = seq_q ? ReplyRr0 : ReplyRr1;
          end else begin
            kind_d  = KIND_REJECT;
            reply_d = seq_q ? ReplyRej1 : ReplyRej0;
          end
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        phase_d = PH_DATA;
        take    = 1'b1;
        if (rx_byte_i == EscFlag) begin
          take_byte = FlagByte;
        end else if (rx_byte_i == EscEsc) begin
          take_byte = EscByte;
        end
      end
      default: begin
        phase_d = (rx_byte_i == FlagByte) ? PH_FLAG : PH_HUNT;
      end
    endcase

    // release the held byte, keep the new one back
    if (take) begin
      if (held_valid_q) begin
        if (count_q >= LenW'(MAX_PAYLOAD)) begin
          ovf_d = 1'b1;
        end else begin
          xor_d   = xor_q ^ held_q;
          count_d = count_q + LenW'(1);
          emit    = 1'b1;
          pbyte_d = held_q;
        end
      end
      held_d       = take_byte;
      held_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = accept & emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_addr_q  <= CmdAddrReset;
      disc_code_q <= DiscReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CMD_ADDR: cmd_addr_q  <= cfg_wdata_i;
        CFG_DISC:     disc_code_q <= cfg_wdata_i;
        default:      cmd_addr_q  <= cmd_addr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      seq_q        <= 1'b0;
      hdr_q        <= '0;
      xor_q        <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q      <= phase_d;
        seq_q        <= seq_d;
        hdr_q        <= hdr_d;
        xor_q        <= xor_d;
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
        count_q      <= count_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      len_q   <= len_d;
      reply_q <= reply_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_length_o = len_q;
  assign reply_control_o  = reply_q;

endmodule

// ===== rtl/sifr_checker.sv =====
`timescale 1ns / 1ps

module sifr_checker
  import sifr_pkg::*;
#(
  parameter int unsigned LenW = 11
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [1:0]      result_kind_o,
  input logic [7:0]      payload_byte_o,
  input logic [LenW-1:0] payload_length_o,
  input logic [7:0]      reply_control_o
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a result only follows an accepted transaction or a waiting result
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result without a transaction");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_DATA) |->
      (payload_length_o == '0) && (reply_control_o == 8'h00))
    else $error("payload result carries frame fields");

  a_accept_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_ACCEPT) |->
      (payload_length_o != '0) && (payload_byte_o == 8'h00) &&
      ((reply_control_o == ReplyRr0) || (reply_control_o == ReplyRr1)))
    else $error("bad accept result");

  a_reject_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_REJECT) |->
      (payload_length_o == '0) && (payload_byte_o == 8'h00) &&
      ((reply_control_o == ReplyRej0) || (reply_control_o == ReplyRej1)))
    else $error("bad reject result");

endmodule

bind stuffed_info_frame_receiver sifr_checker #(.LenW(LenW)) u_sifr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_o    (result_kind_o),
  .payload_byte_o   (payload_byte_o),
  .payload_length_o (payload_length_o),
  .reply_control_o  (reply_control_o)
);
